FILE: rtl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants of the program stream sector header parser.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int SECTOR_BYTES = 2048;
    localparam int OFF_W        = $clog2(SECTOR_BYTES + 1);
    localparam int P_W          = 5;   // packet start: 14..21
    localparam int Q_W          = 10;  // payload start: up to 285
    localparam int F_W          = 17;  // frame start: payload + 3 + pointer

    localparam logic [7:0] PACK_ID    = 8'hba;
    localparam logic [7:0] PRIV1_ID   = 8'hbd;
    localparam logic [7:0] AC3_FIRST  = 8'h80;
    localparam logic [7:0] DTS_FIRST  = 8'h88;
    localparam logic [7:0] DTS_LAST   = 8'h8f;
    localparam logic [7:0] LPCM_FIRST = 8'ha0;
    localparam logic [7:0] LPCM_LAST  = 8'ha7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PACK  = 2'd1,
        ST_NO_PKT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        AK_NONE    = 3'd0,
        AK_AC3     = 3'd1,
        AK_AC3_ERR = 3'd2,
        AK_DTS     = 3'd3,
        AK_LPCM    = 3'd4
    } audio_kind_t;

    // Parse state of one finished sector, handed from capture to decode.
    typedef struct packed {
        logic             pack_bad;
        logic             pkt_bad;
        logic             pts_flag;
        logic             p_valid;
        logic [OFF_W-1:0] byte_count;
        logic [P_W-1:0]   pkt_start;
        logic [15:0]      pes_len;
        logic [F_W-1:0]   frame_start;
        logic [15:0]      unit_ptr;
        logic [47:0]      scr_raw;
        logic [39:0]      pts_raw;
        logic [63:0]      dts_raw;
        logic [31:0]      ac3_win;
        logic [7:0]       stream_id;
        logic [7:0]       sub_id;
        logic [7:0]       lpcm_hdr;
    } psh_snap_t;

endpackage

FILE: rtl/psh_if.sv
// ----------------------------------------------------------------------------
// psh_if
// Handshake channels: sector byte beats in, header result beats out.
// ----------------------------------------------------------------------------
interface psh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] sector_byte;
    logic       sector_end;

    modport source (output valid, sector_byte, sector_end, input ready);
    modport sink   (input valid, sector_byte, sector_end, output ready);
endinterface

interface psh_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pack_status;
    logic [7:0]  stream_ident;
    logic [7:0]  substream_ident;
    logic [41:0] system_clock_ref;
    logic        pts_present;
    logic [32:0] presentation_stamp;
    logic [2:0]  audio_kind;
    logic [3:0]  audio_rate_code;
    logic [5:0]  audio_channel_code;
    logic [13:0] audio_size_code;
    logic [4:0]  audio_bitrate_code;
    logic [7:0]  audio_extras;

    modport source (output valid, pack_status, stream_ident, substream_ident,
                    system_clock_ref, pts_present, presentation_stamp, audio_kind,
                    audio_rate_code, audio_channel_code, audio_size_code,
                    audio_bitrate_code, audio_extras, input ready);
    modport sink   (input valid, pack_status, stream_ident, substream_ident,
                    system_clock_ref, pts_present, presentation_stamp, audio_kind,
                    audio_rate_code, audio_channel_code, audio_size_code,
                    audio_bitrate_code, audio_extras, output ready);
endinterface

FILE: rtl/psh_capture.sv
// ----------------------------------------------------------------------------
// psh_capture
// Track the byte offset, check start codes and grab header bytes per beat.
// ----------------------------------------------------------------------------
module psh_capture
(
    input  logic                clk,
    input  logic                rst_n,
    psh_byte_if.sink            sector,
    output logic                snap_valid,
    input  logic                snap_ready,
    output psh_pkg::psh_snap_t  snap
);
    import psh_pkg::*;

    psh_snap_t        st_reg, st_next, st_upd;
    psh_snap_t        snap_reg;
    logic             snap_valid_reg, snap_valid_next;
    logic [Q_W-1:0]   q_reg, q_next, q_upd;
    logic             q_valid_reg, q_valid_next, q_upd_v;
    logic             f_valid_reg, f_valid_next, f_upd_v;
    logic             accept;
    logic [OFF_W-1:0] off, r, s;
    logic [F_W-1:0]   t;
    logic [7:0]       b;
    logic [2:0]       ci, pi, di;
    logic [1:0]       ai;

    assign sector.ready = !snap_valid_reg || snap_ready;
    assign accept       = sector.valid && sector.ready;
    assign snap_valid   = snap_valid_reg;
    assign snap         = snap_reg;

    always_comb
    begin
        st_upd  = st_reg;
        q_upd   = q_reg;
        q_upd_v = q_valid_reg;
        f_upd_v = f_valid_reg;
        off     = st_reg.byte_count;
        b       = sector.sector_byte;
        r       = off - OFF_W'(st_reg.pkt_start);
        s       = off - OFF_W'(q_reg);
        t       = F_W'(off) - st_reg.frame_start;
        ci      = 3'(4'd9 - off[3:0]);
        pi      = 3'(r[3:0] - 4'd9);
        pi      = 3'd4 - pi;
        di      = 3'(s[4:0] - 5'd9);
        ai      = 2'(t[2:0]);
        if (off < OFF_W'(SECTOR_BYTES))
        begin
            st_upd.byte_count = off + 1'b1;
            if (off < OFF_W'(4))
            begin
                if (b != ((off == OFF_W'(3)) ? PACK_ID :
                          (off == OFF_W'(2)) ? 8'h01 : 8'h00))
                    st_upd.pack_bad = 1'b1;
            end
            else if (off < OFF_W'(10))
            begin
                st_upd.scr_raw[{ci, 3'b000} +: 8] = b;
            end
            if (off == OFF_W'(13))
            begin
                st_upd.pkt_start = P_W'(5'd14 + {2'b00, b[2:0]});
                st_upd.p_valid   = 1'b1;
            end
            if (st_reg.p_valid && off >= OFF_W'(st_reg.pkt_start))
            begin
                if (r < OFF_W'(3))
                begin
                    if (b != ((r == OFF_W'(2)) ? 8'h01 : 8'h00))
                        st_upd.pkt_bad = 1'b1;
                end
                else if (r == OFF_W'(3))
                    st_upd.stream_id = b;
                else if (r == OFF_W'(4))
                    st_upd.pes_len[15:8] = b;
                else if (r == OFF_W'(5))
                    st_upd.pes_len[7:0] = b;
                else if (r == OFF_W'(7))
                begin
                    if (b[7])
                        st_upd.pts_flag = 1'b1;
                end
                else if (r == OFF_W'(8))
                begin
                    q_upd   = Q_W'(st_reg.pkt_start) + Q_W'(9) + Q_W'(b);
                    q_upd_v = 1'b1;
                end
                else if (r >= OFF_W'(9) && r <= OFF_W'(13))
                    st_upd.pts_raw[{pi, 3'b000} +: 8] = b;
            end
            if (q_valid_reg && off >= OFF_W'(q_reg))
            begin
                if (s == OFF_W'(0))
                    st_upd.sub_id = b;
                else if (s == OFF_W'(2))
                    st_upd.unit_ptr[15:8] = b;
                else if (s == OFF_W'(3))
                begin
                    st_upd.unit_ptr[7:0] = b;
                    st_upd.frame_start   = F_W'(q_reg) + F_W'(3)
                                         + F_W'({st_reg.unit_ptr[15:8], b});
                    f_upd_v              = 1'b1;
                end
                else if (s == OFF_W'(5))
                    st_upd.lpcm_hdr = b;
                else if (s >= OFF_W'(9) && s <= OFF_W'(16))
                    st_upd.dts_raw[{3'd7 - di, 3'b000} +: 8] = b;
            end
            if (f_valid_reg && F_W'(off) >= st_reg.frame_start)
            begin
                if (t >= F_W'(4) && t <= F_W'(7))
                    st_upd.ac3_win[{2'd3 - ai, 3'b000} +: 8] = b;
            end
        end
    end

    always_comb
    begin
        st_next         = st_reg;
        q_next          = q_reg;
        q_valid_next    = q_valid_reg;
        f_valid_next    = f_valid_reg;
        snap_valid_next = snap_valid_reg;
        if (snap_ready)
            snap_valid_next = 1'b0;
        if (accept)
        begin
            if (sector.sector_end)
            begin
                // Sector done: hand off the final state, start over.
                snap_valid_next = 1'b1;
                st_next         = '0;
                q_next          = '0;
                q_valid_next    = 1'b0;
                f_valid_next    = 1'b0;
            end
            else
            begin
                st_next      = st_upd;
                q_next       = q_upd;
                q_valid_next = q_upd_v;
                f_valid_next = f_upd_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            q_reg          <= '0;
            q_valid_reg    <= 1'b0;
            f_valid_reg    <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            q_reg          <= q_next;
            q_valid_reg    <= q_valid_next;
            f_valid_reg    <= f_valid_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && sector.sector_end)
            snap_reg <= st_upd;
    end

endmodule

FILE: rtl/psh_decode.sv
// ----------------------------------------------------------------------------
// psh_decode
// Turn a finished sector's parse state into the result beat.
// ----------------------------------------------------------------------------
module psh_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                snap_valid,
    output logic                snap_ready,
    input  psh_pkg::psh_snap_t  snap,
    psh_result_if.source        result
);
    import psh_pkg::*;

    logic             res_valid_reg;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       sid_reg, sid_next, sub_reg, sub_next;
    logic [41:0]      scr_reg, scr_next;
    logic             ptsp_reg, ptsp_next;
    logic [32:0]      pts_reg, pts_next;
    logic [2:0]       kind_reg, kind_next;
    logic [3:0]       rate_reg, rate_next;
    logic [5:0]       chan_reg, chan_next;
    logic [13:0]      size_reg, size_next;
    logic [4:0]       brate_reg, brate_next;
    logic [7:0]       extra_reg, extra_next;

    logic             load;
    logic [32:0]      base;
    logic [7:0]       sub;
    logic [2:0]       acmod;
    logic [5:0]       k, sh;
    logic [F_W:0]     need, limit;
    logic [7:0]       b5, b6, b7, b8, b9, b10, b11, b12;

    assign snap_ready = !res_valid_reg || result.ready;
    assign load       = snap_valid && snap_ready;

    always_comb
    begin
        status_next = ST_OK;
        sid_next    = '0;
        sub_next    = '0;
        scr_next    = '0;
        ptsp_next   = 1'b0;
        pts_next    = '0;
        kind_next   = AK_NONE;
        rate_next   = '0;
        chan_next   = '0;
        size_next   = '0;
        brate_next  = '0;
        extra_next  = '0;
        base  = {snap.scr_raw[45:43], snap.scr_raw[41:27], snap.scr_raw[25:11]};
        sub   = (snap.stream_id == PRIV1_ID) ? snap.sub_id : snap.stream_id;
        acmod = snap.ac3_win[15:13];
        k     = 6'd51;
        if (acmod[0] && acmod != 3'd1)
            k = k + 6'd2;
        if (acmod[2])
            k = k + 6'd2;
        if (acmod == 3'd2)
            k = k + 6'd2;
        sh    = 6'd63 - k;
        need  = (F_W+1)'(snap.frame_start) + (F_W+1)'(k[5:3]) + 1'b1;
        limit = (F_W+1)'(snap.pkt_start) + (F_W+1)'(6) + (F_W+1)'(snap.pes_len);
        if (limit > (F_W+1)'(SECTOR_BYTES))
            limit = (F_W+1)'(SECTOR_BYTES);
        {b5, b6, b7, b8, b9, b10, b11, b12} = snap.dts_raw;
        if (snap.pack_bad || snap.byte_count < OFF_W'(4))
            status_next = ST_NO_PACK;
        else if (snap.pkt_bad || !snap.p_valid
                 || snap.byte_count <= OFF_W'(snap.pkt_start) + OFF_W'(2))
            status_next = ST_NO_PKT;
        else
        begin
            sid_next = snap.stream_id;
            sub_next = sub;
            // base * 300 as shifted adds: 256 + 32 + 8 + 4
            scr_next = {1'b0, base, 8'd0} + {4'd0, base, 5'd0}
                     + {6'd0, base, 3'd0} + {7'd0, base, 2'd0}
                     + {33'd0, snap.scr_raw[9:1]};
            if (snap.stream_id == PRIV1_ID && snap.pts_flag)
            begin
                ptsp_next = 1'b1;
                pts_next  = {snap.pts_raw[35:33], snap.pts_raw[31:17], snap.pts_raw[15:1]};
            end
            if (sub inside {[AC3_FIRST:DTS_FIRST - 8'd1]})
            begin
                if (snap.unit_ptr == 16'd0 || need > limit)
                    kind_next = AK_AC3_ERR;
                else
                begin
                    kind_next  = AK_AC3;
                    rate_next  = {2'b00, snap.ac3_win[31:30]};
                    chan_next  = {3'b000, acmod};
                    size_next  = {8'd0, snap.ac3_win[29:24]};
                    extra_next = {7'd0, snap.ac3_win[sh[4:0]]};
                end
            end
            else if (sub inside {[DTS_FIRST:DTS_LAST]})
            begin
                kind_next  = AK_DTS;
                rate_next  = b8[5:2];
                chan_next  = {b7[3:0], b8[7:6]};
                size_next  = {b5[1:0], b6, b7[7:4]};
                brate_next = {b8[1:0], b9[7:5]};
                extra_next = {b10[7:5], b11[0], b12[7:6], b10[2:1]};
            end
            else if (sub inside {[LPCM_FIRST:LPCM_LAST]})
            begin
                kind_next  = AK_LPCM;
                rate_next  = {2'b00, snap.lpcm_hdr[5:4]};
                chan_next  = {3'b000, snap.lpcm_hdr[2:0]};
                extra_next = {4'b0000, snap.lpcm_hdr[7:6], 2'b00};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (snap_ready)
            res_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            sid_reg    <= sid_next;
            sub_reg    <= sub_next;
            scr_reg    <= scr_next;
            ptsp_reg   <= ptsp_next;
            pts_reg    <= pts_next;
            kind_reg   <= kind_next;
            rate_reg   <= rate_next;
            chan_reg   <= chan_next;
            size_reg   <= size_next;
            brate_reg  <= brate_next;
            extra_reg  <= extra_next;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.pack_status        = status_reg;
    assign result.stream_ident       = sid_reg;
    assign result.substream_ident    = sub_reg;
    assign result.system_clock_ref   = scr_reg;
    assign result.pts_present        = ptsp_reg;
    assign result.presentation_stamp = pts_reg;
    assign result.audio_kind         = kind_reg;
    assign result.audio_rate_code    = rate_reg;
    assign result.audio_channel_code = chan_reg;
    assign result.audio_size_code    = size_reg;
    assign result.audio_bitrate_code = brate_reg;
    assign result.audio_extras       = extra_reg;

`ifndef SYNTHESIS
    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && status_reg != ST_OK |-> kind_reg == AK_NONE && sid_reg == 8'd0)
        else $error("failed header check left fields set");
    a_pts_priv: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && ptsp_reg |-> sid_reg == PRIV1_ID)
        else $error("PTS flagged outside private stream 1");
    a_ac3_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && kind_reg == AK_AC3_ERR |-> rate_reg == 4'd0 && chan_reg == 6'd0)
        else $error("AC3 error result carries audio fields");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && snap_ready |=> res_valid_reg)
        else $error("accepted snapshot produced no result");
`endif

endmodule

FILE: rtl/program_stream_sector_header_parser.sv
// ----------------------------------------------------------------------------
// program_stream_sector_header_parser
// Pack and PES header parser for program stream sectors, one byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one sector byte accepted per cycle, also while a result waits.
// A sector's final state is registered by capture, then by decode's result.
// The capture stage and decode stage each hold one sector; once both hold a
// finished sector and the output is blocked, every further byte stalls.
// Reset (rst_n low, asynchronous) clears all parse state and both valids.
// ----------------------------------------------------------------------------
module program_stream_sector_header_parser
(
    input  logic          clk,
    input  logic          rst_n,
    psh_byte_if.sink      sector,
    psh_result_if.source  result
);
    import psh_pkg::*;

    // Hand-off between capture and decode: final state of one sector.
    psh_snap_t snap;
    logic      snap_valid;
    logic      snap_ready;

    // Track offsets, check start codes and grab raw header bytes per beat.
    psh_capture u_capture
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sector     (sector),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    // Unpack SCR, PTS and audio header fields into the result register.
    psh_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .result     (result)
    );

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the program stream sector header parser: sector
// byte beats are built from directed and random sector layouts, each accepted
// beat advances a local header predictor, and every result beat is compared
// field by field with the oldest predicted header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import psh_pkg::*;

    // Sector layouts the stimulus builder knows.
    localparam int LAY_NOISE   = 0;
    localparam int LAY_ZERO    = 1;
    localparam int LAY_ONES    = 2;
    localparam int LAY_BADPACK = 3;
    localparam int LAY_BADPKT  = 4;
    localparam int LAY_AC3     = 5;
    localparam int LAY_AC3PTR0 = 6;
    localparam int LAY_DTS     = 7;
    localparam int LAY_LPCM    = 8;
    localparam int LAY_OTHER   = 9;
    localparam int LAY_LONG    = 10;

    localparam int RAND_BYTES = 1250;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        status_t     st;
        logic [7:0]  sid;
        logic [7:0]  sub;
        logic [41:0] scr;
        logic        pts_on;
        logic [32:0] pts;
        audio_kind_t kind;
        logic [3:0]  rate;
        logic [5:0]  chan;
        logic [13:0] size;
        logic [4:0]  brate;
        logic [7:0]  extras;
    } hdr_t;

    typedef struct {
        int      layout;
        int      len;
        bit      typed;
        status_t st;
    } row_t;

    logic clk;
    logic rst_n;

    psh_byte_if   sector_ch ();
    psh_result_if result_ch ();

    program_stream_sector_header_parser uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sector (sector_ch),
        .result (result_ch)
    );

    hdr_t      hdr_q[$];
    logic [7:0] sec_bytes[$];
    int        err_cnt;
    bit        calm;
    bit        hold_go;
    bit        use_typed;
    status_t   typed_st;

    // Local parser state, one sector at a time.
    int          off_cnt, pkt_at, pay_at, pes_len, frm_at, au_ptr;
    bit          pack_bad, pkt_bad, pts_flag, p_ok, q_ok, f_ok;
    logic [47:0] scr_raw;
    logic [39:0] pts_raw;
    logic [63:0] dts_raw;
    logic [31:0] ac3_win;
    logic [7:0]  sid_b, sub_b, lpcm_b;

    // Clear all parse state, as after reset or after a sector's last beat.
    function void clear_parse();
        off_cnt = 0; pkt_at = 0; pay_at = 0; pes_len = 0; frm_at = 0; au_ptr = 0;
        pack_bad = 0; pkt_bad = 0; pts_flag = 0; p_ok = 0; q_ok = 0; f_ok = 0;
        scr_raw = '0; pts_raw = '0; dts_raw = '0; ac3_win = '0;
        sid_b = '0; sub_b = '0; lpcm_b = '0;
    endfunction

    function void take_byte(int off, logic [7:0] b);
        int r;
        int s;
        int t;
        if (off < 4)
        begin
            if (b != ((off == 3) ? PACK_ID : (off == 2 ? 8'h01 : 8'h00)))
                pack_bad = 1;
        end
        else if (off < 10)
            scr_raw[8*(9-off) +: 8] = b;
        if (off == 13)
        begin
            pkt_at = 14 + int'(b[2:0]);
            p_ok = 1;
        end
        if (p_ok && off >= pkt_at)
        begin
            r = off - pkt_at;
            if (r < 3)
            begin
                if (b != ((r == 2) ? 8'h01 : 8'h00))
                    pkt_bad = 1;
            end
            else if (r == 3) sid_b = b;
            else if (r == 4) pes_len = (pes_len & 'hff) | (int'(b) << 8);
            else if (r == 5) pes_len = (pes_len & 'hff00) | int'(b);
            else if (r == 7)
            begin
                if (b[7]) pts_flag = 1;
            end
            else if (r == 8)
            begin
                pay_at = pkt_at + 9 + int'(b);
                q_ok = 1;
            end
            else if (r >= 9 && r <= 13)
                pts_raw[8*(13-r) +: 8] = b;
        end
        if (q_ok && off >= pay_at)
        begin
            s = off - pay_at;
            if (s == 0) sub_b = b;
            else if (s == 2) au_ptr = (au_ptr & 'hff) | (int'(b) << 8);
            else if (s == 3)
            begin
                au_ptr = (au_ptr & 'hff00) | int'(b);
                frm_at = pay_at + 3 + au_ptr;
                f_ok = 1;
            end
            else if (s == 5) lpcm_b = b;
            else if (s >= 9 && s <= 16) dts_raw[8*(16-s) +: 8] = b;
        end
        if (f_ok && off >= frm_at)
        begin
            t = off - frm_at;
            if (t >= 4 && t <= 7) ac3_win[8*(7-t) +: 8] = b;
        end
    endfunction

    // Build the header result of the sector seen so far.
    function hdr_t finish_header();
        hdr_t        h;
        logic [63:0] base;
        logic [63:0] full;
        logic [7:0]  d5, d6, d7, d8, d9, d10, d11, d12;
        logic [2:0]  acmod;
        int          k;
        int          lim;
        h = '{st: ST_OK, kind: AK_NONE, default: '0};
        if (pack_bad || off_cnt < 4)
        begin
            h.st = ST_NO_PACK;
            return h;
        end
        if (pkt_bad || !p_ok || off_cnt <= pkt_at + 2)
        begin
            h.st = ST_NO_PKT;
            return h;
        end
        base = {31'd0, scr_raw[45:43], scr_raw[41:27], scr_raw[25:11]};
        full = base * 64'd300 + {55'd0, scr_raw[9:1]};
        h.sid = sid_b;
        h.sub = (sid_b == PRIV1_ID) ? sub_b : sid_b;
        h.scr = full[41:0];
        if (sid_b == PRIV1_ID && pts_flag)
        begin
            h.pts_on = 1;
            h.pts = {pts_raw[35:33], pts_raw[31:17], pts_raw[15:1]};
        end
        if (h.sub >= AC3_FIRST && h.sub < DTS_FIRST)
        begin
            acmod = ac3_win[15:13];
            k = 51;
            if (acmod[0] && acmod != 3'd1) k += 2;
            if (acmod[2]) k += 2;
            if (acmod == 3'd2) k += 2;
            lim = pkt_at + 6 + pes_len;
            if (lim > SECTOR_BYTES) lim = SECTOR_BYTES;
            if (au_ptr == 0 || frm_at + k / 8 + 1 > lim)
                h.kind = AK_AC3_ERR;
            else
            begin
                h.kind = AK_AC3;
                h.rate = {2'b00, ac3_win[31:30]};
                h.chan = {3'b000, acmod};
                h.size = {8'd0, ac3_win[29:24]};
                h.extras = {7'd0, ac3_win[63-k]};
            end
        end
        else if (h.sub >= DTS_FIRST && h.sub <= DTS_LAST)
        begin
            d5 = dts_raw[63:56]; d6 = dts_raw[55:48]; d7 = dts_raw[47:40];
            d8 = dts_raw[39:32]; d9 = dts_raw[31:24]; d10 = dts_raw[23:16];
            d11 = dts_raw[15:8]; d12 = dts_raw[7:0];
            h.kind = AK_DTS;
            h.rate = d8[5:2];
            h.chan = {d7[3:0], d8[7:6]};
            h.size = {d5[1:0], d6, d7[7:4]};
            h.brate = {d8[1:0], d9[7:5]};
            h.extras = {d10[7:5], d11[0], d12[7:6], d10[2:1]};
        end
        else if (h.sub >= LPCM_FIRST && h.sub <= LPCM_LAST)
        begin
            h.kind = AK_LPCM;
            h.rate = {2'b00, lpcm_b[5:4]};
            h.chan = {3'b000, lpcm_b[2:0]};
            h.extras = {3'b000, 1'b0, lpcm_b[7:6], 2'b00};
        end
        return h;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // Clock.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: fail a run that stops making progress.
    initial
    begin
        #20ms;
        $display("tb: errors");
        $finish;
    end

    // Predict on each accepted byte beat, check each accepted result beat.
    always @(posedge clk)
    begin
        hdr_t h;
        hdr_t w;
        if (rst_n)
        begin
            if (sector_ch.valid && sector_ch.ready)
            begin
                if (off_cnt < SECTOR_BYTES)
                begin
                    take_byte(off_cnt, sector_ch.sector_byte);
                    off_cnt++;
                end
                if (sector_ch.sector_end)
                begin
                    h = finish_header();
                    // Directed rows with an obvious answer carry it typed in.
                    if (use_typed)
                        h = '{st: typed_st, kind: AK_NONE, default: '0};
                    hdr_q.push_back(h);
                    clear_parse();
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (hdr_q.size() == 0)
                    report("result beat with none expected", 64'd1, 64'd0);
                else
                begin
                    w = hdr_q.pop_front();
                    if (result_ch.pack_status !== w.st)
                        report("pack_status", result_ch.pack_status, w.st);
                    if (result_ch.stream_ident !== w.sid)
                        report("stream_ident", result_ch.stream_ident, w.sid);
                    if (result_ch.substream_ident !== w.sub)
                        report("substream_ident", result_ch.substream_ident, w.sub);
                    if (result_ch.system_clock_ref !== w.scr)
                        report("system_clock_ref", result_ch.system_clock_ref, w.scr);
                    if (result_ch.pts_present !== w.pts_on)
                        report("pts_present", result_ch.pts_present, w.pts_on);
                    if (result_ch.presentation_stamp !== w.pts)
                        report("presentation_stamp", result_ch.presentation_stamp, w.pts);
                    if (result_ch.audio_kind !== w.kind)
                        report("audio_kind", result_ch.audio_kind, w.kind);
                    if (result_ch.audio_rate_code !== w.rate)
                        report("audio_rate_code", result_ch.audio_rate_code, w.rate);
                    if (result_ch.audio_channel_code !== w.chan)
                        report("audio_channel_code", result_ch.audio_channel_code, w.chan);
                    if (result_ch.audio_size_code !== w.size)
                        report("audio_size_code", result_ch.audio_size_code, w.size);
                    if (result_ch.audio_bitrate_code !== w.brate)
                        report("audio_bitrate_code", result_ch.audio_bitrate_code, w.brate);
                    if (result_ch.audio_extras !== w.extras)
                        report("audio_extras", result_ch.audio_extras, w.extras);
                end
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int held;
        result_ch.ready = 0;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                result_ch.ready = 0;
                held++;
                if (held == HOLD_LEN)
                begin
                    hold_go = 0;
                    held = 0;
                end
            end
            else if (calm)
                result_ch.ready = 1;
            else
                result_ch.ready = ($urandom_range(0, 99) >= 31);
        end
    end

    // Fill sec_bytes with one sector of the given layout.
    task automatic build_sector(int layout, int len);
        int         p_idx;
        int         len_idx;
        int         ptr;
        int         plen;
        int         idx;
        logic [7:0] sub;
        sec_bytes.delete();
        if (layout == LAY_NOISE || layout == LAY_ZERO || layout == LAY_ONES)
        begin
            repeat (len)
                sec_bytes.push_back(layout == LAY_ZERO ? 8'h00 :
                                    layout == LAY_ONES ? 8'hff : 8'($urandom));
            return;
        end
        sec_bytes = '{8'h00, 8'h00, 8'h01, PACK_ID};
        if (layout == LAY_BADPACK)
        begin
            idx = $urandom_range(0, 3);
            sec_bytes[idx] = sec_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        repeat (10) sec_bytes.push_back(8'($urandom));
        repeat (sec_bytes[13][2:0]) sec_bytes.push_back(8'($urandom));
        p_idx = sec_bytes.size();
        sec_bytes.push_back(8'h00);
        sec_bytes.push_back(8'h00);
        sec_bytes.push_back(8'h01);
        if (layout == LAY_BADPKT)
        begin
            idx = p_idx + $urandom_range(0, 2);
            sec_bytes[idx] = sec_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        sec_bytes.push_back(layout == LAY_OTHER ? 8'($urandom) : PRIV1_ID);
        len_idx = sec_bytes.size();
        sec_bytes.push_back(8'h00);
        sec_bytes.push_back(8'h00);
        sec_bytes.push_back(8'($urandom));
        sec_bytes.push_back(8'($urandom));
        sec_bytes.push_back(8'($urandom_range(0, 20)));
        repeat (sec_bytes[p_idx+8]) sec_bytes.push_back(8'($urandom));
        case (layout)
            LAY_AC3, LAY_AC3PTR0, LAY_LONG: sub = AC3_FIRST + 8'($urandom_range(0, 7));
            LAY_DTS:  sub = DTS_FIRST + 8'($urandom_range(0, 7));
            LAY_LPCM: sub = LPCM_FIRST + 8'($urandom_range(0, 7));
            default:  sub = 8'($urandom);
        endcase
        sec_bytes.push_back(sub);
        sec_bytes.push_back(8'($urandom));
        if (layout == LAY_AC3PTR0) ptr = 0;
        else if (layout == LAY_LONG) ptr = $urandom_range(1900, 2100) - sec_bytes.size();
        else if (layout == LAY_AC3) ptr = $urandom_range(1, 24);
        else ptr = $urandom_range(0, 65535);
        sec_bytes.push_back(8'(ptr >> 8));
        sec_bytes.push_back(8'(ptr));
        while (sec_bytes.size() < len) sec_bytes.push_back(8'($urandom));
        // PES length lands near the real end, sometimes short of the frame.
        plen = (layout == LAY_LONG) ? 'hffff : len - p_idx - 6 + $urandom_range(0, 24) - 12;
        if (plen < 0) plen = 0;
        sec_bytes[len_idx] = 8'(plen >> 8);
        sec_bytes[len_idx+1] = 8'(plen);
        while (sec_bytes.size() > len) void'(sec_bytes.pop_back());
    endtask

    // Offer one byte beat, idling at random, until it is accepted.
    task automatic send_byte(logic [7:0] b, logic last);
        bit done;
        done = 0;
        while (!done)
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 99) < 31)
            begin
                sector_ch.valid = 0;
                @(posedge clk);
            end
            else
            begin
                sector_ch.valid = 1;
                sector_ch.sector_byte = b;
                sector_ch.sector_end = last;
                @(posedge clk);
                done = sector_ch.ready;
            end
        end
    endtask

    // Offer a whole sector, one byte beat after another, then drop valid.
    task automatic send_sector();
        foreach (sec_bytes[i])
            send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
        @(negedge clk);
        sector_ch.valid = 0;
    endtask

    // Directed sectors: extremes, start code errors, every audio kind.
    row_t dir_rows[] = '{
        '{LAY_ZERO,    1,    1, ST_NO_PACK},
        '{LAY_ZERO,    40,   1, ST_NO_PACK},
        '{LAY_ONES,    40,   1, ST_NO_PACK},
        '{LAY_BADPACK, 60,   1, ST_NO_PACK},
        '{LAY_BADPKT,  60,   1, ST_NO_PKT},
        '{LAY_AC3,     16,   0, ST_OK},
        '{LAY_AC3,     80,   0, ST_OK},
        '{LAY_AC3PTR0, 80,   0, ST_OK},
        '{LAY_DTS,     80,   0, ST_OK},
        '{LAY_LPCM,    80,   0, ST_OK},
        '{LAY_OTHER,   60,   0, ST_OK},
        '{LAY_LONG,    2060, 0, ST_OK}
    };

    initial
    begin
        int sent;
        int nsec;
        int pick;
        int len;
        int layout;
        rst_n = 0;
        sector_ch.valid = 0;
        sector_ch.sector_byte = '0;
        sector_ch.sector_end = 0;
        err_cnt = 0;
        calm = 0;
        hold_go = 0;
        use_typed = 0;
        typed_st = ST_OK;
        clear_parse();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (dir_rows[i])
        begin
            build_sector(dir_rows[i].layout, dir_rows[i].len);
            use_typed = dir_rows[i].typed;
            typed_st = dir_rows[i].st;
            send_sector();
        end
        use_typed = 0;

        sent = 0;
        nsec = 0;
        while (sent < RAND_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                layout = LAY_NOISE;
                len = $urandom_range(1, 30);
            end
            else if (pick < 25)
            begin
                layout = (pick < 20) ? LAY_BADPACK : LAY_BADPKT;
                len = $urandom_range(10, 60);
            end
            else
            begin
                layout = $urandom_range(LAY_AC3, LAY_OTHER);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(30, 90);
            end
            build_sector(layout, len);
            // Run a stretch with no idling on either side.
            calm = (nsec >= 12 && nsec < 18);
            // Block the result side while sectors keep coming.
            if (nsec == 4) hold_go = 1;
            // Drain everything before carrying on.
            if (nsec == 10)
                while (hdr_q.size() != 0) @(posedge clk);
            send_sector();
            sent += sec_bytes.size();
            nsec++;
        end
        calm = 0;

        while (hdr_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/psh_pkg.sv
rtl/psh_if.sv
rtl/psh_capture.sv
rtl/psh_decode.sv
rtl/program_stream_sector_header_parser.sv
sim/tb.sv
